// ----- sv/skwn_pkg.sv -----
// ----------------------------------------------------------------------------
// skwn_pkg
// Shared types and constants for the spatial keyword node summary block.
// ----------------------------------------------------------------------------
package skwn_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [15:0]        DIST_MAX  = 16'hFFFF;

  typedef struct packed {
    logic add;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic any_point;
    logic pos_last;
  } status_t;

endpackage

// ----- sv/skwn_ctrl.sv -----
// ----------------------------------------------------------------------------
// skwn_ctrl
// Controller: input handshake, finish walk sequencing and output beat valid.
// ----------------------------------------------------------------------------
module skwn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  output logic             out_valid,
  input  logic             out_ready,
  input  skwn_pkg::status_t sts,
  output skwn_pkg::cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;

  assign load_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == skwn_pkg::OP_ADD) begin
            cmd.add = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (!sts.any_point || sts.pos_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/skwn_dp.sv -----
// ----------------------------------------------------------------------------
// skwn_dp
// Datapath: bounding box, keyword union, per-keyword minimum distance lanes,
// walk position counters and the output beat register.
// ----------------------------------------------------------------------------
module skwn_dp #(
  parameter int DIMENSIONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  skwn_pkg::cmd_t      cmd,
  output skwn_pkg::status_t   sts,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic [7:0]          in_keyword_mask,
  input  logic [2:0]          in_dim_index,
  input  logic [15:0]         in_distance,
  output logic [2:0]          out_table_row,
  output logic [2:0]          out_table_col,
  output logic [15:0]         out_min_distance,
  output logic signed [31:0]  out_box_min_x,
  output logic signed [31:0]  out_box_min_y,
  output logic signed [31:0]  out_box_max_x,
  output logic signed [31:0]  out_box_max_y,
  output logic [7:0]          out_keyword_union,
  output logic                out_node_nonempty,
  output logic                out_last
);

  localparam int                IDX_W    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DIMENSIONS - 1);
  localparam logic [3:0]        DIM_LIM  = 4'(DIMENSIONS);
  localparam logic [7:0]        KW_MASK  = 8'((9'd1 << DIMENSIONS) - 9'd1);

  logic signed [31:0] low_x_r, low_y_r, high_x_r, high_y_r;
  logic [7:0]         seen_r;
  logic               any_point_r;
  logic [IDX_W-1:0]   row_r, col_r;
  logic [15:0]        tab_r   [DIMENSIONS][DIMENSIONS];
  logic [DIMENSIONS-1:0] valid_r [DIMENSIONS];

  logic [7:0]         kw;
  logic               dim_ok;
  logic [IDX_W-1:0]   col_sel;
  logic [15:0]        lane_rd [DIMENSIONS];
  logic [DIMENSIONS-1:0] lane_wr;
  logic               pos_last;
  logic [15:0]        entry;

  assign kw       = in_keyword_mask & KW_MASK;
  assign dim_ok   = ({1'b0, in_dim_index} < DIM_LIM);
  assign col_sel  = cmd.emit ? col_r : in_dim_index[IDX_W-1:0];
  assign pos_last = (row_r == LAST_IDX) && (col_r == LAST_IDX);

  assign sts.any_point = any_point_r;
  assign sts.pos_last  = pos_last;

  always_comb begin
    for (int r = 0; r < DIMENSIONS; r++) begin
      lane_rd[r] = valid_r[r][col_sel] ? tab_r[r][col_sel] : skwn_pkg::DIST_MAX;
      lane_wr[r] = cmd.add && dim_ok && kw[r] && (in_distance < lane_rd[r]);
    end
  end

  assign entry = seen_r[row_r] ? lane_rd[row_r] : 16'd0;

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIMENSIONS; r++) begin
      if (lane_wr[r]) begin
        tab_r[r][col_sel] <= in_distance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      low_x_r     <= skwn_pkg::COORD_MAX;
      low_y_r     <= skwn_pkg::COORD_MAX;
      high_x_r    <= skwn_pkg::COORD_MIN;
      high_y_r    <= skwn_pkg::COORD_MIN;
      seen_r      <= '0;
      any_point_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      for (int r = 0; r < DIMENSIONS; r++) begin
        valid_r[r] <= '0;
      end
    end else begin
      if (cmd.add) begin
        if (in_point_x < low_x_r)  low_x_r  <= in_point_x;
        if (in_point_y < low_y_r)  low_y_r  <= in_point_y;
        if (in_point_x > high_x_r) high_x_r <= in_point_x;
        if (in_point_y > high_y_r) high_y_r <= in_point_y;
        seen_r      <= seen_r | kw;
        any_point_r <= 1'b1;
        for (int r = 0; r < DIMENSIONS; r++) begin
          if (lane_wr[r]) begin
            valid_r[r][col_sel] <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        if (col_r == LAST_IDX) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (any_point_r) begin
        out_table_row     <= 3'(row_r);
        out_table_col     <= 3'(col_r);
        out_min_distance  <= entry;
        out_box_min_x     <= low_x_r;
        out_box_min_y     <= low_y_r;
        out_box_max_x     <= high_x_r;
        out_box_max_y     <= high_y_r;
        out_keyword_union <= seen_r;
        out_node_nonempty <= 1'b1;
        out_last          <= pos_last;
      end else begin
        out_table_row     <= '0;
        out_table_col     <= '0;
        out_min_distance  <= '0;
        out_box_min_x     <= '0;
        out_box_min_y     <= '0;
        out_box_max_x     <= '0;
        out_box_max_y     <= '0;
        out_keyword_union <= '0;
        out_node_nonempty <= 1'b0;
        out_last          <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/spatial_keyword_node_summary.sv -----
// ----------------------------------------------------------------------------
// spatial_keyword_node_summary
// Leaf node summary builder: bounding box, keyword union and per-keyword
// minimum distance table, emitted entry by entry on a finish item.
//
//   Channel  Direction  Handshake              Beat
//   in_      input      in_valid / in_ready    one add or finish item
//   out_     output     out_valid / out_ready  one table entry with box
//
// An add item updates one column of each keyword lane whose mask bit is set
// and whose entry exceeds its distance. A finish item walks the table row by
// row at one beat per cycle unless stalled: DIMENSIONS*DIMENSIONS beats, or a
// single beat for an empty node. No new item is taken until the last walk
// beat is loaded into the output register. A stalled output holds its beat and
// pauses the walk. Reset is synchronous and clears all summary state at once.
// ----------------------------------------------------------------------------
module spatial_keyword_node_summary #(
  parameter int DIMENSIONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic [7:0]         in_keyword_mask,
  input  logic [2:0]         in_dim_index,
  input  logic [15:0]        in_distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_table_row,
  output logic [2:0]         out_table_col,
  output logic [15:0]        out_min_distance,
  output logic signed [31:0] out_box_min_x,
  output logic signed [31:0] out_box_min_y,
  output logic signed [31:0] out_box_max_x,
  output logic signed [31:0] out_box_max_y,
  output logic [7:0]         out_keyword_union,
  output logic               out_node_nonempty,
  output logic               out_last
);

  skwn_pkg::cmd_t    cmd;
  skwn_pkg::status_t sts;

  skwn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skwn_dp #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_keyword_mask   (in_keyword_mask),
    .in_dim_index      (in_dim_index),
    .in_distance       (in_distance),
    .out_table_row     (out_table_row),
    .out_table_col     (out_table_col),
    .out_min_distance  (out_min_distance),
    .out_box_min_x     (out_box_min_x),
    .out_box_min_y     (out_box_min_y),
    .out_box_max_x     (out_box_max_x),
    .out_box_max_y     (out_box_max_y),
    .out_keyword_union (out_keyword_union),
    .out_node_nonempty (out_node_nonempty),
    .out_last          (out_last)
  );

endmodule
